### design/vcds_pkg.sv
package vcds_pkg;

    // Default edge length of the cubic voxel grid.
    localparam int DEFAULT_GRID_SIZE = 32;

    // Field widths fixed by the interface.
    localparam int SIZE_W  = 6;
    localparam int POS_W   = 5;
    localparam int CODE_W  = 3;
    localparam int TOTAL_W = 16;

    // Internal coordinates are as wide as a size register, so that a scan
    // position along any axis fits.
    localparam int COORD_W = SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // Command codes.
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_X_SIZE = 2'd0;
    localparam logic [1:0] REG_Y_SIZE = 2'd1;
    localparam logic [1:0] REG_Z_SIZE = 2'd2;

    // Scan axis codes, taken from the upper orientation bits.
    localparam logic [1:0] AXIS_Z = 2'd0;
    localparam logic [1:0] AXIS_X = 2'd1;
    localparam logic [1:0] AXIS_Y = 2'd2;

    localparam logic [2:0] ORIENT_LAST = 3'd5;

    // Voxel codes.
    localparam logic [CODE_W-1:0] CODE_EMPTY     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_MATERIAL  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MARK_BASE = 3'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } coord_t;

    typedef struct packed {
        logic   en;
        coord_t coord;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        coord_t            coord;
        logic [CODE_W-1:0] data;
    } wr_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } state_t;

endpackage

### design/vcds_grid.sv
module vcds_grid
    import vcds_pkg::*;
#(
    parameter int GRID_SIZE = DEFAULT_GRID_SIZE
)
(
    input  logic              clk,
    input  rd_req_t           rd_req,
    input  wr_req_t           wr_req,
    output logic [CODE_W-1:0] rd_data
);

    localparam int DEPTH  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    // Linear address: x is the slowest axis, z the fastest.
    function automatic logic [ADDR_W-1:0] lin_addr(input coord_t c);
        int a;
        begin
            a = (int'(c.x) * GRID_SIZE + int'(c.y)) * GRID_SIZE + int'(c.z);
            return a[ADDR_W-1:0];
        end
    endfunction

    assign rd_addr = lin_addr(rd_req.coord);
    assign wr_addr = lin_addr(wr_req.coord);

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_addr] <= wr_req.data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_req.en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/voxel_column_depth_scanner_core.sv
// Voxel column depth scanner. A command is taken when start is high and busy
// is low; its single result appears on the result ports for exactly one cycle
// with done high, and must be captured then, since the receiver cannot stall
// the block. A voxel write or an unused mode gives its result in the cycle
// after the command; a voxel read first passes through the ST_READ state. A
// column scan reads one voxel per cycle from the grid memory, overlapping the
// next read with the check and mark-write of the current voxel, and gives its
// result after the last voxel of the column, or earlier when material stops
// the scan. busy is already low in the cycle that shows a result, so the next
// command can be taken there. The grid memory is not cleared at reset: every
// voxel must be written before it is read or scanned. Size registers may only
// be written while no command is in flight.
module voxel_column_depth_scanner_core
    import vcds_pkg::*;
#(
    parameter int GRID_SIZE = DEFAULT_GRID_SIZE
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [POS_W-1:0]   x_pos,
    input  logic [POS_W-1:0]   y_pos,
    input  logic [POS_W-1:0]   z_pos,
    input  logic               solid,
    input  logic [2:0]         orientation,
    input  logic               restart_total,
    // Result channel.
    output logic               done,
    output logic [SIZE_W-1:0]  height,
    output logic [SIZE_W-1:0]  column_volume,
    output logic [TOTAL_W-1:0] total_volume,
    output logic [CODE_W-1:0]  voxel_code,
    // Configuration channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [SIZE_W-1:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]  x_size_reg, y_size_reg, z_size_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [SIZE_W-1:0]  sx, sy, sz;
    logic               accept;
    logic               in_range;
    logic               scan_ok;
    logic [1:0]         in_axis;
    logic [SIZE_W-1:0]  in_len;
    coord_t             in_coord;

    // Scan context.
    coord_t             base_reg, base_next;
    logic [2:0]         orient_reg, orient_next;
    logic [SIZE_W-1:0]  len_reg, len_next;
    logic [SIZE_W-1:0]  k_reg, k_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [SIZE_W-1:0]  rd_pos_reg, rd_pos_next;
    logic [SIZE_W-1:0]  col_cnt_reg, col_cnt_next;
    logic               read_ok_reg, read_ok_next;
    logic               down;
    logic [SIZE_W-1:0]  issue_pos;
    logic               stop;

    // Result registers.
    logic               done_reg, done_next;
    logic [SIZE_W-1:0]  height_reg, height_next;
    logic [SIZE_W-1:0]  colvol_reg, colvol_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               mark;
    logic               total_clear;

    rd_req_t            rd_req;
    wr_req_t            wr_req;
    logic [CODE_W-1:0]  rd_data;

    // Zero means one voxel; anything above the grid saturates.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        begin
            if (r == '0)
                return SIZE_W'(1);
            else if (int'(r) > GRID_SIZE)
                return SIZE_W'(GRID_SIZE);
            else
                return r;
        end
    endfunction

    // Coordinate of scan position p in the column given by base and axis.
    function automatic coord_t scan_coord(input coord_t b, input logic [1:0] ax,
                                          input logic [SIZE_W-1:0] p);
        coord_t c;
        begin
            c = b;
            if (ax == AXIS_X)
                c.x = p;
            if (ax == AXIS_Y)
                c.y = p;
            if (ax == AXIS_Z)
                c.z = p;
            return c;
        end
    endfunction

    assign sx = eff_size(x_size_reg);
    assign sy = eff_size(y_size_reg);
    assign sz = eff_size(z_size_reg);

    assign accept   = start && !busy;
    assign in_coord = '{x: {1'b0, x_pos}, y: {1'b0, y_pos}, z: {1'b0, z_pos}};
    assign in_range = (in_coord.x < sx) && (in_coord.y < sy) && (in_coord.z < sz);
    assign in_axis  = orientation[2:1];
    assign in_len   = (in_axis == AXIS_Z) ? sz : ((in_axis == AXIS_X) ? sx : sy);
    assign scan_ok  = (orientation <= ORIENT_LAST)
                   && ((in_axis == AXIS_X) || (in_coord.x < sx))
                   && ((in_axis == AXIS_Y) || (in_coord.y < sy))
                   && ((in_axis == AXIS_Z) || (in_coord.z < sz));

    // "+" orientations scan from the top of the column downward.
    assign down      = !orient_reg[0];
    assign issue_pos = down ? (len_reg - SIZE_W'(1) - k_reg) : k_reg;

    // Size registers; an index past the last register is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_size_reg <= SIZE_RESET;
            y_size_reg <= SIZE_RESET;
            z_size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_SIZE: x_size_reg <= cfg_data;
                REG_Y_SIZE: y_size_reg <= cfg_data;
                REG_Z_SIZE: z_size_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Running total, saturating.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (total_clear)
        begin
            total_reg <= '0;
        end
        else if (mark && (total_reg != TOTAL_MAX))
        begin
            total_reg <= total_reg + TOTAL_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        orient_reg  <= orient_next;
        len_reg     <= len_next;
        k_reg       <= k_next;
        rd_pos_reg  <= rd_pos_next;
        col_cnt_reg <= col_cnt_next;
        read_ok_reg <= read_ok_next;
        height_reg  <= height_next;
        colvol_reg  <= colvol_next;
        code_reg    <= code_next;
    end

    // Sequencer: command decode, voxel read, and the pipelined column scan.
    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        orient_next  = orient_reg;
        len_next     = len_reg;
        k_next       = k_reg;
        rd_vld_next  = 1'b0;
        rd_pos_next  = rd_pos_reg;
        col_cnt_next = col_cnt_reg;
        read_ok_next = read_ok_reg;
        done_next    = 1'b0;
        height_next  = height_reg;
        colvol_next  = colvol_reg;
        code_next    = code_reg;
        mark         = 1'b0;
        total_clear  = 1'b0;
        stop         = 1'b0;
        rd_req       = '0;
        wr_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    height_next = '0;
                    colvol_next = '0;
                    code_next   = CODE_EMPTY;
                    case (mode)
                        MODE_WRITE:
                        begin
                            wr_req.en    = in_range;
                            wr_req.coord = in_coord;
                            wr_req.data  = solid ? CODE_MATERIAL : CODE_EMPTY;
                            done_next    = 1'b1;
                        end
                        MODE_READ:
                        begin
                            rd_req.en    = in_range;
                            rd_req.coord = in_coord;
                            read_ok_next = in_range;
                            state_next   = ST_READ;
                        end
                        MODE_SCAN:
                        begin
                            total_clear = restart_total;
                            if (scan_ok)
                            begin
                                base_next    = in_coord;
                                orient_next  = orientation;
                                len_next     = in_len;
                                k_next       = '0;
                                col_cnt_next = '0;
                                state_next   = ST_SCAN;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                code_next  = read_ok_reg ? rd_data : CODE_EMPTY;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // Check the voxel read in the previous cycle.
                if (rd_vld_reg)
                begin
                    if (rd_data == CODE_MATERIAL)
                    begin
                        stop        = 1'b1;
                        height_next = down ? (rd_pos_reg + SIZE_W'(1))
                                           : (len_reg - rd_pos_reg);
                    end
                    else if (rd_data == CODE_EMPTY)
                    begin
                        wr_req.en    = 1'b1;
                        wr_req.coord = scan_coord(base_reg, orient_reg[2:1], rd_pos_reg);
                        wr_req.data  = CODE_MARK_BASE + orient_reg;
                        col_cnt_next = col_cnt_reg + SIZE_W'(1);
                        mark         = 1'b1;
                    end
                end

                // Finish on material or after the last voxel; else read ahead.
                if (stop || ((k_reg == len_reg) && !rd_vld_reg))
                begin
                    colvol_next = col_cnt_reg;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (k_reg < len_reg)
                begin
                    rd_req.en    = 1'b1;
                    rd_req.coord = scan_coord(base_reg, orient_reg[2:1], issue_pos);
                    rd_vld_next  = 1'b1;
                    rd_pos_next  = issue_pos;
                    k_next       = k_reg + SIZE_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    vcds_grid #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid (
        .clk     (clk),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (rd_data)
    );

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign height        = height_reg;
    assign column_volume = colvol_reg;
    assign total_volume  = total_reg;
    assign voxel_code    = code_reg;

    // The read-ahead never targets the voxel being marked in the same cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_req.en && wr_req.en) |-> (rd_req.coord != wr_req.coord))
        else $error("grid read and write hit the same voxel");

    // Every command that leaves the busy states delivers its result.
    a_busy_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result");

    // The scan counter never runs past the column length.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (k_reg <= len_reg))
        else $error("scan index beyond column length");

    // The running total only drops through a restarted scan.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg < $past(total_reg)) |->
            $past(accept && (mode == MODE_SCAN) && restart_total))
        else $error("running total decreased without restart");

endmodule

### bench/testbench.sv
module testbench;

    import vcds_pkg::*;

    localparam int GRID        = DEFAULT_GRID_SIZE;
    localparam int CELLS       = GRID * GRID * GRID;
    localparam int STALL_LIMIT = 1000;

    // Command and register codes that the package does not name.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        XY_POS,
        XY_NEG,
        YZ_POS,
        YZ_NEG,
        XZ_POS,
        XZ_NEG,
        ORIENT_SPARE6,
        ORIENT_SPARE7
    } orient_e;

    typedef struct packed {
        logic [1:0]       mode;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic             solid;
        logic [2:0]       orient;
        logic             restart;
    } voxel_cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  height;
        logic [SIZE_W-1:0]  column_volume;
        logic [TOTAL_W-1:0] total_volume;
        logic [CODE_W-1:0]  voxel_code;
    } column_report_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = '0;
    logic [POS_W-1:0]   x_pos = '0;
    logic [POS_W-1:0]   y_pos = '0;
    logic [POS_W-1:0]   z_pos = '0;
    logic               solid = 1'b0;
    logic [2:0]         orientation = '0;
    logic               restart_total = 1'b0;
    logic               done;
    logic [SIZE_W-1:0]  height;
    logic [SIZE_W-1:0]  column_volume;
    logic [TOTAL_W-1:0] total_volume;
    logic [CODE_W-1:0]  voxel_code;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [SIZE_W-1:0]  cfg_data = '0;

    // Pending items, the item on the bus and the expected reports.
    voxel_cmd_t     cmd_queue[$];
    voxel_cmd_t     bus_cmd;
    column_report_t pending_reports[$];

    // Shadow of the block: grid codes, running total and size registers.
    logic [CODE_W-1:0]  voxel_model [0:CELLS-1];
    logic [TOTAL_W-1:0] running_total = '0;
    logic [SIZE_W-1:0]  size_reg [0:2] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};

    // Cells that the stimulus has written so far; nothing else is read.
    bit cell_written [0:CELLS-1];

    int n_queued;
    int n_sent;
    int n_accepted;
    int n_results;
    int n_scans;
    int n_writes;
    int n_reads;
    int n_settings;
    int error_count;
    int quiet_cycles;

    voxel_column_depth_scanner_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .z_pos         (z_pos),
        .solid         (solid),
        .orientation   (orientation),
        .restart_total (restart_total),
        .done          (done),
        .height        (height),
        .column_volume (column_volume),
        .total_volume  (total_volume),
        .voxel_code    (voxel_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int eff_size(input logic [SIZE_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > GRID)
            return GRID;
        return r;
    endfunction

    function automatic int cell_at(input int x, input int y, input int z);
        return (x * GRID + y) * GRID + z;
    endfunction

    function automatic voxel_cmd_t make_cmd(input logic [1:0] m, input int x, input int y,
                                            input int z, input logic s, input orient_e o,
                                            input logic r);
        voxel_cmd_t c;
        c.mode    = m;
        c.x       = POS_W'(x);
        c.y       = POS_W'(y);
        c.z       = POS_W'(z);
        c.solid   = s;
        c.orient  = o;
        c.restart = r;
        return c;
    endfunction

    task automatic report_error(input string what, input int got, input int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Works out the report of one accepted item and updates the shadow state.
    task automatic apply_command(input voxel_cmd_t c);
        column_report_t rep;
        int             sx, sy, sz, len, k, pos, idx;
        logic [1:0]     axis;
        bit             descend;
        bit             in_range;
        rep = '0;
        sx  = eff_size(size_reg[REG_X_SIZE]);
        sy  = eff_size(size_reg[REG_Y_SIZE]);
        sz  = eff_size(size_reg[REG_Z_SIZE]);
        in_range = c.x < sx && c.y < sy && c.z < sz;
        case (c.mode)
            MODE_WRITE:
            begin
                n_writes++;
                if (in_range)
                    voxel_model[cell_at(c.x, c.y, c.z)] = c.solid ? CODE_MATERIAL : CODE_EMPTY;
            end
            MODE_READ:
            begin
                n_reads++;
                if (in_range)
                    rep.voxel_code = voxel_model[cell_at(c.x, c.y, c.z)];
            end
            MODE_SCAN:
            begin
                n_scans++;
                if (c.restart)
                    running_total = '0;
                if (c.orient <= ORIENT_LAST)
                begin
                    axis     = c.orient[2:1];
                    descend  = !c.orient[0];
                    len      = (axis == AXIS_Z) ? sz : (axis == AXIS_X) ? sx : sy;
                    in_range = (axis == AXIS_X || c.x < sx) && (axis == AXIS_Y || c.y < sy)
                               && (axis == AXIS_Z || c.z < sz);
                    // Walk in from the open side until material stops the scan.
                    for (k = 0; in_range && k < len; k++)
                    begin
                        pos = descend ? len - 1 - k : k;
                        idx = cell_at((axis == AXIS_X) ? pos : c.x,
                                      (axis == AXIS_Y) ? pos : c.y,
                                      (axis == AXIS_Z) ? pos : c.z);
                        if (voxel_model[idx] == CODE_MATERIAL)
                        begin
                            rep.height = SIZE_W'(descend ? pos + 1 : len - pos);
                            break;
                        end
                        if (voxel_model[idx] == CODE_EMPTY)
                        begin
                            voxel_model[idx] = CODE_MARK_BASE + c.orient;
                            rep.column_volume++;
                            if (running_total != TOTAL_MAX)
                                running_total++;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        rep.total_volume = running_total;
        pending_reports.push_back(rep);
    endtask

    // Queues one item, first writing any cell that a read or scan would reach
    // before it has ever been written.
    task automatic queue_command(input voxel_cmd_t c);
        voxel_cmd_t fill;
        int         sx, sy, sz, len, p, cx, cy, cz;
        logic [1:0] axis;
        sx = eff_size(size_reg[REG_X_SIZE]);
        sy = eff_size(size_reg[REG_Y_SIZE]);
        sz = eff_size(size_reg[REG_Z_SIZE]);
        axis = c.orient[2:1];
        len  = (axis == AXIS_Z) ? sz : (axis == AXIS_X) ? sx : sy;
        for (p = 0; p < GRID; p++)
        begin
            cx = c.x;
            cy = c.y;
            cz = c.z;
            if (c.mode == MODE_SCAN)
            begin
                if (c.orient > ORIENT_LAST || p >= len)
                    break;
                if (axis == AXIS_X)
                    cx = p;
                else if (axis == AXIS_Y)
                    cy = p;
                else
                    cz = p;
            end
            else if (c.mode != MODE_READ || p > 0)
                break;
            if (cx < sx && cy < sy && cz < sz && !cell_written[cell_at(cx, cy, cz)])
            begin
                fill = make_cmd(MODE_WRITE, cx, cy, cz, $urandom_range(0, 99) < 22,
                                orient_e'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
                queue_command(fill);
            end
        end
        if (c.mode == MODE_WRITE && c.x < sx && c.y < sy && c.z < sz)
            cell_written[cell_at(c.x, c.y, c.z)] = 1'b1;
        cmd_queue.push_back(c);
        n_queued++;
    endtask

    // Mostly well-formed items inside the grid in use, the rest unrestricted.
    task automatic queue_random_item();
        voxel_cmd_t c;
        int         pick;
        pick      = $urandom_range(0, 99);
        c.mode    = 2'($urandom_range(0, 3));
        c.x       = POS_W'($urandom_range(0, 31));
        c.y       = POS_W'($urandom_range(0, 31));
        c.z       = POS_W'($urandom_range(0, 31));
        c.solid   = 1'($urandom_range(0, 1));
        c.orient  = 3'($urandom_range(0, 7));
        c.restart = $urandom_range(0, 99) < 4;
        if (pick < 82)
        begin
            c.x = POS_W'($urandom_range(0, eff_size(size_reg[REG_X_SIZE]) - 1));
            c.y = POS_W'($urandom_range(0, eff_size(size_reg[REG_Y_SIZE]) - 1));
            c.z = POS_W'($urandom_range(0, eff_size(size_reg[REG_Z_SIZE]) - 1));
            if (pick < 36)
            begin
                c.mode   = MODE_SCAN;
                c.orient = 3'($urandom_range(XY_POS, XZ_NEG));
            end
            else if (pick < 62)
            begin
                c.mode  = MODE_WRITE;
                c.solid = $urandom_range(0, 99) < 30;
            end
            else
                c.mode = MODE_READ;
        end
        queue_command(c);
    endtask

    // Returns once every queued item is taken and every report has come back.
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || n_accepted != n_sent || pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_size_reg(input logic [1:0] idx, input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx != REG_UNUSED)
            size_reg[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sizes(input int xs, input int ys, input int zs);
        wait_idle();
        write_size_reg(REG_X_SIZE, SIZE_W'(xs));
        write_size_reg(REG_Y_SIZE, SIZE_W'(ys));
        write_size_reg(REG_Z_SIZE, SIZE_W'(zs));
        // The spare index must leave every size alone.
        write_size_reg(REG_UNUSED, SIZE_W'($urandom_range(0, 63)));
        n_settings++;
    endtask

    task automatic run_phase(input int xs, input int ys, input int zs, input int count);
        int target;
        set_sizes(xs, ys, zs);
        target = n_queued + count;
        while (n_queued < target)
            queue_random_item();
    endtask

    // Driver: puts the next item on the bus once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || n_accepted == n_sent))
        begin
            if (cmd_queue.size() != 0
                && ((n_sent >= 600 && n_sent < 900) || $urandom_range(0, 99) >= 12))
            begin
                bus_cmd = cmd_queue.pop_front();
                start         <= 1'b1;
                mode          <= bus_cmd.mode;
                x_pos         <= bus_cmd.x;
                y_pos         <= bus_cmd.y;
                z_pos         <= bus_cmd.z;
                solid         <= bus_cmd.solid;
                orientation   <= bus_cmd.orient;
                restart_total <= bus_cmd.restart;
                n_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // Acceptance: each item taken is run through the shadow model.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            apply_command(bus_cmd);
            n_accepted++;
        end
    end

    // Monitor: each report is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_reports
        column_report_t want;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_reports.size() == 0)
                report_error("report with no item waiting, height", height, 0);
            else
            begin
                want = pending_reports.pop_front();
                if (height !== want.height)
                    report_error("height", height, want.height);
                if (column_volume !== want.column_volume)
                    report_error("column_volume", column_volume, want.column_volume);
                if (total_volume !== want.total_volume)
                    report_error("total_volume", total_volume, want.total_volume);
                if (voxel_code !== want.voxel_code)
                    report_error("voxel_code", voxel_code, want.voxel_code);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no activity for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes: far corner and origin, read back, unused mode.
        queue_command(make_cmd(MODE_WRITE, 31, 31, 31, 1'b1, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_READ, 31, 31, 31, 1'b0, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_WRITE, 0, 0, 0, 1'b0, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_READ, 0, 0, 0, 1'b0, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_UNUSED, 0, 0, 0, 1'b0, XY_POS, 1'b0));

        // Tiny grid: every orientation, spare orientations, outside coordinates.
        set_sizes(2, 2, 2);
        queue_command(make_cmd(MODE_WRITE, 0, 0, 1, 1'b1, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 0, 0, 31, 1'b0, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 0, 0, 0, 1'b0, XY_NEG, 1'b0));
        queue_command(make_cmd(MODE_READ, 0, 0, 0, 1'b0, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 31, 1, 1, 1'b1, YZ_POS, 1'b1));
        queue_command(make_cmd(MODE_SCAN, 0, 1, 1, 1'b0, YZ_NEG, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 1, 31, 0, 1'b0, XZ_POS, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 1, 0, 0, 1'b0, XZ_NEG, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 1, 1, 1, 1'b0, ORIENT_SPARE6, 1'b1));
        queue_command(make_cmd(MODE_SCAN, 0, 0, 0, 1'b1, ORIENT_SPARE7, 1'b0));
        queue_command(make_cmd(MODE_WRITE, 31, 0, 0, 1'b1, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_READ, 0, 31, 0, 1'b0, XY_POS, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 0, 31, 0, 1'b0, XY_POS, 1'b1));
        queue_command(make_cmd(MODE_SCAN, 0, 0, 31, 1'b0, XZ_POS, 1'b0));
        queue_command(make_cmd(MODE_UNUSED, 31, 31, 31, 1'b1, ORIENT_SPARE7, 1'b1));
        queue_command(make_cmd(MODE_WRITE, 1, 1, 1, 1'b1, YZ_NEG, 1'b1));
        queue_command(make_cmd(MODE_READ, 1, 1, 1, 1'b1, XZ_NEG, 1'b0));
        queue_command(make_cmd(MODE_SCAN, 1, 1, 0, 1'b0, XY_NEG, 1'b0));

        // Random phases over a spread of grid shapes, extremes included.
        run_phase(4, 4, 4, 220);
        run_phase(0, 63, 3, 150);
        run_phase(32, 1, 1, 130);
        run_phase(8, 8, 8, 220);
        run_phase(3, 5, 2, 180);
        run_phase(40, 2, 32, 200);
        run_phase(63, 63, 63, 250);
        run_phase(1, 0, 1, 100);

        wait_idle();
        repeat (40) @(posedge clk);
        while (pending_reports.size() != 0)
        begin
            report_error("report never arrived, height", 0, pending_reports[0].height);
            void'(pending_reports.pop_front());
        end

        $display("Ran %0d items (%0d scans, %0d writes, %0d reads) over %0d grid shapes.",
                 n_accepted, n_scans, n_writes, n_reads, n_settings);
        $display("Checked %0d reports; %0d mismatches.", n_results, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
